>>> sv/pcx_rle_palette_decoder_core_assert.svh
// assertion macros used by the decoder datapath
`ifndef PCX_RLE_PALETTE_DECODER_CORE_ASSERT_SVH
`define PCX_RLE_PALETTE_DECODER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define PCXD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// condition must never be seen at a clock edge outside reset
`define PCXD_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define PCXD_ASSERT(lbl, clk, rstn, prop, msg)
`define PCXD_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

>>> sv/pcxd_pkg.sv
package pcxd_pkg;

  localparam int DEF_MAX_WIDTH  = 320;
  localparam int DEF_MAX_HEIGHT = 256;

  localparam int COL_W    = 9;
  localparam int ROW_W    = 8;
  localparam int CNT_W    = 6;
  localparam int IDX_W    = 8;
  localparam int COLOUR_W = 24;
  localparam int OP_W     = 2;

  // op codes carried in tuser of the input channel
  localparam logic [OP_W-1:0] OP_PALETTE = 2'd0;
  localparam logic [OP_W-1:0] OP_DATA    = 2'd1;
  localparam logic [OP_W-1:0] OP_START   = 2'd2;

  // top two bits of a run header byte
  localparam logic [1:0] RUN_MARK = 2'b11;

  // register select, address bit 2
  localparam logic REG_LAST_COLUMN = 1'b0;
  localparam logic REG_LAST_ROW    = 1'b1;

  localparam logic [COL_W-1:0] RESET_LAST_COLUMN = 9'd319;
  localparam logic [ROW_W-1:0] RESET_LAST_ROW    = 8'd199;

  typedef struct packed {
    logic [COL_W-1:0] last_column;
    logic [ROW_W-1:0] last_row;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic run_start;
    logic rem_one;
    logic out_busy;
  } dp_status_t;

endpackage

>>> sv/pcxd_cfg.sv
module pcxd_cfg #(
  parameter int MAX_WIDTH  = pcxd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = pcxd_pkg::DEF_MAX_HEIGHT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready,
  output pcxd_pkg::cfg_t     cfg
);
  import pcxd_pkg::*;

  localparam int ROW_CAP_W = ROW_W + 2;
  localparam logic [COL_W-1:0]     COL_CAP = COL_W'(MAX_WIDTH - 1);
  localparam logic [ROW_CAP_W-1:0] ROW_CAP = ROW_CAP_W'(MAX_HEIGHT - 1);

  logic [COL_W-1:0] last_column_r, last_column_nxt;
  logic [ROW_W-1:0] last_row_r, last_row_nxt;
  logic             wr;
  logic [COL_W-1:0] col_in;
  logic [ROW_W-1:0] row_in;

  assign cfg_pready = 1'b1;
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign col_in     = cfg_pwdata[COL_W-1:0];
  assign row_in     = cfg_pwdata[ROW_W-1:0];

  // values beyond the image limits saturate
  always_comb begin
    last_column_nxt = last_column_r;
    last_row_nxt    = last_row_r;
    if (wr) begin
      if (cfg_paddr[2] == REG_LAST_COLUMN) begin
        last_column_nxt = (col_in > COL_CAP) ? COL_CAP : col_in;
      end else begin
        last_row_nxt = ({2'b00, row_in} > ROW_CAP) ? ROW_CAP[ROW_W-1:0] : row_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_column_r <= RESET_LAST_COLUMN;
      last_row_r    <= RESET_LAST_ROW;
    end else begin
      last_column_r <= last_column_nxt;
      last_row_r    <= last_row_nxt;
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_LAST_ROW) ? {{(32-ROW_W){1'b0}}, last_row_r}
                                                     : {{(32-COL_W){1'b0}}, last_column_r};

  assign cfg.last_column = last_column_r;
  assign cfg.last_row    = last_row_r;

endmodule

>>> sv/pcxd_ctrl.sv
module pcxd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic                 out_tready,
  input  pcxd_pkg::dp_status_t status,
  output pcxd_pkg::ctrl_cmd_t  cmd
);
  import pcxd_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_r, state_nxt;

  assign in_tready  = (state_r == ST_IDLE);
  assign cmd.accept = in_tvalid && in_tready;
  // a pixel moves into the output register when it is free or being taken
  assign cmd.step   = (state_r == ST_RUN) && (!status.out_busy || out_tready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.accept && status.run_start) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (cmd.step && status.rem_one) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> sv/pcxd_dp.sv
`include "pcx_rle_palette_decoder_core_assert.svh"

module pcxd_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pcxd_pkg::ctrl_cmd_t  cmd,
  input  pcxd_pkg::cfg_t       cfg,
  input  logic [1:0]           in_tuser,
  input  logic [39:0]          in_tdata,
  input  logic                 out_tready,
  output logic                 out_tvalid,
  output logic [23:0]          out_tdata,
  output logic                 out_tlast,
  output logic                 out_tuser,
  output pcxd_pkg::dp_status_t status
);
  import pcxd_pkg::*;

  localparam int POS_W = COL_W + 1;

  logic [OP_W-1:0]  op;
  logic [IDX_W-1:0] pal_idx;
  logic [7:0]       pal_red, pal_green, pal_blue, data_byte;

  logic [POS_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             fin_r, fin_nxt;
  logic             pend_r, pend_nxt;
  logic [CNT_W-1:0] pcnt_r, pcnt_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic             lastf_r, lastf_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [COLOUR_W-1:0] out_colour_r;
  logic             out_last_r, out_done_r;

  logic [COLOUR_W-1:0] palette_mem [0:(1<<IDX_W)-1];
  logic [COLOUR_W-1:0] pal_q;

  logic             wr_en, rd_en, emit;
  logic [POS_W-1:0] lim, lc_ext, col_step;

  // working values of the data byte decode
  logic [POS_W-1:0] c1;
  logic [ROW_W-1:0] r1;
  logic             f1, p1, pix, lastf;
  logic [CNT_W-1:0] pc1, cnt;

  assign op        = in_tuser;
  assign pal_idx   = in_tdata[7:0];
  assign pal_red   = in_tdata[15:8];
  assign pal_green = in_tdata[23:16];
  assign pal_blue  = in_tdata[31:24];
  assign data_byte = in_tdata[39:32];

  assign lc_ext   = {1'b0, cfg.last_column};
  assign lim      = lc_ext + POS_W'(1);
  assign col_step = col_r + POS_W'(1);

  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    fin_nxt   = fin_r;
    pend_nxt  = pend_r;
    pcnt_nxt  = pcnt_r;
    rem_nxt   = rem_r;
    lastf_nxt = lastf_r;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    emit      = 1'b0;
    c1        = col_r;
    r1        = row_r;
    f1        = fin_r;
    p1        = pend_r;
    pc1       = pcnt_r;
    pix       = 1'b0;
    lastf     = 1'b0;
    cnt       = '0;
    if (cmd.accept) begin
      unique case (op)
        OP_PALETTE: wr_en = 1'b1;
        OP_START: begin
          col_nxt  = '0;
          row_nxt  = '0;
          fin_nxt  = 1'b0;
          pend_nxt = 1'b0;
          pcnt_nxt = '0;
        end
        OP_DATA: begin
          // row limit lowered under an open image
          if (!f1 && (r1 > cfg.last_row)) begin
            f1 = 1'b1;
            p1 = 1'b0;
          end
          // column limit lowered: close the row first
          if (!f1 && !p1 && (c1 > lc_ext)) begin
            c1 = '0;
            if (r1 >= cfg.last_row) f1 = 1'b1;
            else                    r1 = r1 + ROW_W'(1);
          end
          if (!f1) begin
            if (p1) begin
              p1  = 1'b0;
              cnt = pc1;
              pc1 = '0;
              pix = 1'b1;
            end else if (data_byte[7:6] == RUN_MARK) begin
              p1  = 1'b1;
              pc1 = data_byte[CNT_W-1:0];
            end else begin
              cnt = CNT_W'(1);
              pix = 1'b1;
            end
          end
          if (pix) begin
            lastf = (r1 == cfg.last_row);
            // clip the run at the right edge of the last row
            if (lastf && (({1'b0, c1} + {{(POS_W+1-CNT_W){1'b0}}, cnt}) > {1'b0, lim})) begin
              cnt = (c1 >= lim) ? '0 : CNT_W'(lim - c1);
            end
            if (cnt != '0) begin
              emit      = 1'b1;
              rd_en     = 1'b1;
              rem_nxt   = cnt;
              lastf_nxt = lastf;
            end else if (c1 > lc_ext) begin
              c1 = '0;
              if (r1 >= cfg.last_row) f1 = 1'b1;
              else                    r1 = r1 + ROW_W'(1);
            end
          end
          col_nxt  = c1;
          row_nxt  = r1;
          fin_nxt  = f1;
          pend_nxt = p1;
          pcnt_nxt = pc1;
        end
        default: ;
      endcase
    end else if (cmd.step) begin
      rem_nxt = rem_r - CNT_W'(1);
      col_nxt = col_step;
      // end of run: wrap to the next row once past the right edge
      if ((rem_r == CNT_W'(1)) && (col_step >= lim)) begin
        col_nxt = '0;
        if (row_r >= cfg.last_row) fin_nxt = 1'b1;
        else                       row_nxt = row_r + ROW_W'(1);
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.step)        out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (wr_en) palette_mem[pal_idx] <= {pal_red, pal_green, pal_blue};
    if (rd_en) pal_q <= palette_mem[data_byte];
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      out_colour_r <= pal_q;
      out_last_r   <= (rem_r == CNT_W'(1));
      out_done_r   <= lastf_r && (col_step == lim);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      fin_r       <= 1'b0;
      pend_r      <= 1'b0;
      pcnt_r      <= '0;
      rem_r       <= '0;
      lastf_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      fin_r       <= fin_nxt;
      pend_r      <= pend_nxt;
      pcnt_r      <= pcnt_nxt;
      rem_r       <= rem_nxt;
      lastf_r     <= lastf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_colour_r[7:0], out_colour_r[15:8], out_colour_r[23:16]};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_done_r;

  assign status.run_start = emit;
  assign status.rem_one   = (rem_r == CNT_W'(1));
  assign status.out_busy  = out_valid_r;

  `PCXD_ASSERT_NEVER(a_accept_in_run, clk, rst_n, cmd.accept && cmd.step, "request taken during a run")
  `PCXD_ASSERT(a_step_has_count, clk, rst_n, cmd.step |-> (rem_r != '0), "pixel step with no count left")
  `PCXD_ASSERT(a_no_overwrite, clk, rst_n, (out_valid_r && !out_tready) |-> !cmd.step, "pending pixel overwritten")
  `PCXD_ASSERT(a_run_ends, clk, rst_n, (cmd.step && (rem_r == CNT_W'(1))) |=> (rem_r == '0), "run count did not close")

endmodule

>>> sv/pcx_rle_palette_decoder_core.sv
// 8-bit run-length image decoder with a 256-colour palette. Requests on the input channel
// carry an op in tuser: palette write, compressed byte, or start of a new image (position and
// any open run are cleared, the palette is kept). A palette write, a start and a run header
// are each done on acceptance. A single-pixel byte is accepted and read from the palette,
// then its colour moves into the output register. A run colour byte with count n is sent out
// one pixel per cycle while the output register is free or being taken, paced by the run
// counter from the single registered palette read port; a zero-length run produces nothing.
// The output register lets the next request in while the last pixel of a byte still waits
// to be taken. Runs may spill past the end of a row; on the last row they are clipped at the
// right edge, and bytes after the last row are dropped until a start. tlast marks the final
// pixel of a byte and tuser the pixel that completes the image. Reading a palette entry that
// was never written gives an undefined colour. last_column sits at address 0 and last_row at
// address 4; both saturate at the image size limits.
module pcx_rle_palette_decoder_core #(
  parameter int MAX_WIDTH  = pcxd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = pcxd_pkg::DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration port, register select on address bit 2
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  // input requests
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // palette_index, palette_red, palette_green, palette_blue, data_byte
  input  logic [1:0]  in_tuser,   // op
  // decoded pixels
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // red, green, blue
  output logic        out_tlast,  // run_last
  output logic        out_tuser   // image_done
);
  import pcxd_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  // image size registers
  pcxd_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // idle / run sequencer, owns the input handshake and pixel stepping
  pcxd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  // palette memory, position tracking, run counter and output register
  pcxd_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .cfg        (cfg),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .status     (status)
  );

endmodule
